### rtl/pca_pkg.sv
// Shared constants for the conditional anti-windup PID block.
// Depends on nothing; every rtl file refers to it by scoped names.
package pca_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int STEP_FRAC      = 16;

  localparam int IN_W   = 32;
  localparam int LIM_W  = 31;
  localparam int TS_W   = 16;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_KP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI   = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OLIM = 3'd3;
  localparam logic [IDX_W-1:0] REG_ILIM = 3'd4;

  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [LIM_W-1:0] LIM_RESET = 31'd65536;

endpackage

### rtl/pid_conditional_antiwindup.sv
// Top level of the PID step with conditional anti-windup and derivative on measurement.
// Sequences pca_mul and pca_div; constants come from pca_pkg.
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: target, measurement, time_step; tuser: req
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: drive; tuser: drive_clamped
// cfg       in   cfg_we_i (no wait)           cfg_idx_i selects register, cfg_data_i value
//
// A clear or zero-step transaction goes from accept straight to the output load.
// A compute step runs accept and setup, then each serial multiply and the divide, then
// the sum and output load. With the integral update taken that is five multiplies and
// the divide; the first step after reset or clear skips the divide and one multiply,
// and a step that takes no integral update skips another multiply. One item is in work at
// a time; the result register holds a result while m_axis_tready is low and the next item
// may already be taken. Reset restores gains, limits and state.
module pid_conditional_antiwindup #(
  parameter int DATA_WIDTH = pca_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pca_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [79:0]                s_axis_tdata,  // target[31:0], measurement, time_step
  input  logic                       s_axis_tuser,  // req_type
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // drive[31:0]
  output logic                       m_axis_tuser,  // drive_clamped
  input  logic                       cfg_we_i,
  input  logic [pca_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [pca_pkg::CFG_W-1:0]  cfg_data_i
);
  localparam int W  = DATA_WIDTH;
  localparam int XW = ((W > pca_pkg::IN_W) ? W : pca_pkg::IN_W) + 2;
  localparam int THR = ((1 << FRAC_BITS) + 50) / 100;
  localparam logic signed [XW-1:0] MAXX = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [XW-1:0] MINX = ~MAXX;
  localparam logic signed [XW-1:0] THRX = XW'(THR);
  localparam logic signed [W-1:0]  DMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0]  DMIN = ~DMAX;
  localparam logic [W+15:0]        QMAX = {17'd0, {(W - 1){1'b1}}};
  localparam logic [W+15:0]        QNEG = {16'd0, 1'b1, {(W - 1){1'b0}}};

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_P    = 4'd2;
  localparam logic [3:0] ST_T    = 4'd3;
  localparam logic [3:0] ST_E    = 4'd4;
  localparam logic [3:0] ST_I    = 4'd5;
  localparam logic [3:0] ST_DV   = 4'd6;
  localparam logic [3:0] ST_D    = 4'd7;
  localparam logic [3:0] ST_SUM  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] v);
    logic signed [W-1:0] r;
    if (v > MAXX) begin
      r = DMAX;
    end else if (v < MINX) begin
      r = DMIN;
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [XW-1:0] ext(input logic signed [W-1:0] v);
    return XW'(v);
  endfunction

  logic [3:0] state_q;
  logic       run_q;

  logic signed [pca_pkg::IN_W-1:0] kp_q, ki_q, kd_q;
  logic [pca_pkg::LIM_W-1:0]       olim_q, ilim_q;

  logic signed [W-1:0] integ_q, last_q;
  logic                first_q;

  logic signed [pca_pkg::IN_W-1:0] sp_raw_q, ms_raw_q;
  logic [pca_pkg::TS_W-1:0]        ts_q;
  logic signed [W-1:0]             ms_q, err_q, p_q, i_q, d_q, deriv_q;
  logic signed [W-1:0]             res_drive_q;
  logic                            res_clamp_q;

  logic [31:0] out_data_q;
  logic        out_clamp_q, out_valid_q;

  logic signed [W-1:0] kp_w, ki_w, kd_w, omax, imax, sp_w, ms_w, delta, o1, o2;
  logic [W-1:0]        mag;
  logic                small_sp, cond;
  logic signed [W-1:0] pot, new_integ;

  logic                mul_start, mul_step, mul_done;
  logic signed [W:0]   mul_a, mul_b;
  logic signed [W-1:0] mul_res;
  logic                div_start, div_done;
  logic [W+15:0]       div_quo;

  always_comb begin
    kp_w  = sat_x(XW'(kp_q));
    ki_w  = sat_x(XW'(ki_q));
    kd_w  = sat_x(XW'(kd_q));
    omax  = sat_x(XW'({1'b0, olim_q}));
    imax  = sat_x(XW'({1'b0, ilim_q}));
    sp_w  = sat_x(XW'(sp_raw_q));
    ms_w  = sat_x(XW'(ms_raw_q));
    small_sp = (ext(sp_w) < THRX) && (ext(sp_w) > -THRX);
    delta = sat_x(ext(ms_q) - ext(last_q));
    mag   = delta[W-1] ? (~delta + 1'b1) : delta;
    pot   = sat_x(ext(p_q) + ext(mul_res));
    // Integrate inside the band, or when the error drives back toward it.
    cond  = ((pot < omax) && (pot > -omax)) ||
            ((err_q > 0) && (pot < -omax)) ||
            ((err_q < 0) && (pot > omax));
    new_integ = sat_x(ext(integ_q) + ext(mul_res));
    if (new_integ > imax) begin
      new_integ = imax;
    end else if (new_integ < -imax) begin
      new_integ = -imax;
    end
    o1 = sat_x(ext(p_q) + ext(i_q));
    o2 = sat_x(ext(o1) + ext(d_q));
  end

  always_comb begin
    mul_a    = (W + 1)'(kp_w);
    mul_b    = (W + 1)'(err_q);
    mul_step = 1'b0;
    unique case (state_q)
      ST_T, ST_I: begin
        mul_a = (W + 1)'(ki_w);
        mul_b = (W + 1)'(integ_q);
      end
      ST_E: begin
        mul_a    = (W + 1)'(err_q);
        mul_b    = {{(W + 1 - pca_pkg::TS_W){1'b0}}, ts_q};
        mul_step = 1'b1;
      end
      ST_D: begin
        mul_a = (W + 1)'(kd_w);
        mul_b = (W + 1)'(deriv_q);
      end
      default: begin
      end
    endcase
    mul_start = !run_q && ((state_q == ST_P) || (state_q == ST_T) ||
                           (state_q == ST_E) || (state_q == ST_I) || (state_q == ST_D));
    div_start = !run_q && (state_q == ST_DV);
  end

  pca_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (mul_start),
    .step_shift_i(mul_step),
    .a_i         (mul_a),
    .b_i         (mul_b),
    .done_o      (mul_done),
    .res_o       (mul_res)
  );

  pca_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .mag_i  (mag),
    .ts_i   (ts_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      olim_q <= pca_pkg::LIM_RESET;
      ilim_q <= pca_pkg::LIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pca_pkg::REG_KP:   kp_q   <= cfg_data_i;
        pca_pkg::REG_KI:   ki_q   <= cfg_data_i;
        pca_pkg::REG_KD:   kd_q   <= cfg_data_i;
        pca_pkg::REG_OLIM: olim_q <= cfg_data_i[pca_pkg::LIM_W-1:0];
        pca_pkg::REG_ILIM: ilim_q <= cfg_data_i[pca_pkg::LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      integ_q     <= '0;
      last_q      <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
      ms_q        <= '0;
      err_q       <= '0;
      p_q         <= '0;
      i_q         <= '0;
      d_q         <= '0;
      deriv_q     <= '0;
      res_drive_q <= '0;
      res_clamp_q <= 1'b0;
      out_data_q  <= '0;
      out_clamp_q <= 1'b0;
    end else begin
      if (mul_start || div_start) begin
        run_q <= 1'b1;
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            res_drive_q <= '0;
            res_clamp_q <= 1'b0;
            if (s_axis_tuser == pca_pkg::REQ_CLEAR) begin
              integ_q <= '0;
              last_q  <= '0;
              first_q <= 1'b1;
              state_q <= ST_OUT;
            end else if (s_axis_tdata[79:64] == '0) begin
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          ms_q  <= ms_w;
          err_q <= sat_x(ext(sp_w) - ext(ms_w));
          if (small_sp) begin
            integ_q <= '0;
          end
          state_q <= ST_P;
        end
        ST_P: begin
          if (mul_done) begin
            p_q     <= mul_res;
            run_q   <= 1'b0;
            state_q <= ST_T;
          end
        end
        ST_T: begin
          if (mul_done) begin
            run_q   <= 1'b0;
            state_q <= cond ? ST_E : ST_I;
          end
        end
        ST_E: begin
          if (mul_done) begin
            integ_q <= new_integ;
            run_q   <= 1'b0;
            state_q <= ST_I;
          end
        end
        ST_I: begin
          if (mul_done) begin
            i_q     <= mul_res;
            d_q     <= '0;
            run_q   <= 1'b0;
            state_q <= first_q ? ST_SUM : ST_DV;
          end
        end
        ST_DV: begin
          if (div_done) begin
            if (!delta[W-1]) begin
              deriv_q <= (div_quo > QMAX) ? DMAX : div_quo[W-1:0];
            end else begin
              deriv_q <= (div_quo > QNEG) ? DMIN : (~div_quo[W-1:0] + 1'b1);
            end
            run_q   <= 1'b0;
            state_q <= ST_D;
          end
        end
        ST_D: begin
          if (mul_done) begin
            d_q     <= (mul_res == DMIN) ? DMAX : -mul_res;
            run_q   <= 1'b0;
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (o2 > omax) begin
            res_drive_q <= omax;
            res_clamp_q <= 1'b1;
          end else if (o2 < -omax) begin
            res_drive_q <= -omax;
            res_clamp_q <= 1'b1;
          end else begin
            res_drive_q <= o2;
            res_clamp_q <= 1'b0;
          end
          last_q  <= ms_q;
          first_q <= 1'b0;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_data_q  <= 32'(res_drive_q);
            out_clamp_q <= res_clamp_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      sp_raw_q <= s_axis_tdata[31:0];
      ms_raw_q <= s_axis_tdata[63:32];
      ts_q     <= s_axis_tdata[79:64];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_clamp_q;

endmodule

### rtl/pca_mul.sv
// Bit-serial signed multiplier with floor shift and saturation.
// One multiplier bit per cycle; uses pca_pkg for the step shift.
module pca_mul #(
  parameter int DATA_WIDTH = pca_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pca_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         step_shift_i,
  input  logic signed [DATA_WIDTH:0]   a_i,
  input  logic signed [DATA_WIDTH:0]   b_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] res_o
);
  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W + 3;
  localparam int CW = $clog2(W + 1);
  localparam logic signed [PW-1:0] PMAX = {{(W + 4){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [PW-1:0] PMIN = ~PMAX;

  logic signed [W:0]   a_q;
  logic signed [W+1:0] acc_q, acc_d, sum;
  logic        [W:0]   lo_q, lo_d;
  logic        [CW-1:0] cnt_q;
  logic                busy_q, done_q;
  logic signed [W+1:0] addend;
  logic signed [PW-1:0] prod, shifted;

  // The top bit of the multiplier has negative weight.
  always_comb begin
    addend = (W + 2)'(a_q);
    if (cnt_q == CW'(W)) begin
      addend = -addend;
    end
    sum   = acc_q + (lo_q[0] ? addend : '0);
    acc_d = sum >>> 1;
    lo_d  = {sum[0], lo_q[W:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(W)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      lo_q  <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      lo_q  <= lo_d;
    end
  end

  // The accumulator carries the sign, so the full product keeps it.
  always_comb begin
    prod    = $signed({acc_q, lo_q});
    shifted = step_shift_i ? (prod >>> pca_pkg::STEP_FRAC) : (prod >>> FRAC_BITS);
    if (shifted > PMAX) begin
      res_o = PMAX[W-1:0];
    end else if (shifted < PMIN) begin
      res_o = PMIN[W-1:0];
    end else begin
      res_o = shifted[W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

### rtl/pca_div.sv
// Restoring radix-2 divider for the derivative quotient (mag * 2^16) / ts.
// One quotient bit per cycle; uses pca_pkg for the step width.
module pca_div #(
  parameter int DATA_WIDTH = pca_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DATA_WIDTH-1:0]         mag_i,
  input  logic [pca_pkg::TS_W-1:0]      ts_i,
  output logic                          done_o,
  output logic [DATA_WIDTH+15:0]        quo_o
);
  localparam int NW = DATA_WIDTH + pca_pkg::STEP_FRAC;
  localparam int CW = $clog2(NW);
  localparam int TW = pca_pkg::TS_W;

  logic [NW-1:0] nq_q;
  logic [TW-1:0] rem_q, den_q;
  logic [TW:0]   r2, diff;
  logic          ge;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  always_comb begin
    r2   = {rem_q, nq_q[NW-1]};
    diff = r2 - {1'b0, den_q};
    ge   = r2 >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // Numerator bits leave at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= {mag_i, {pca_pkg::STEP_FRAC{1'b0}}};
      rem_q <= '0;
      den_q <= ts_i;
    end else if (busy_q) begin
      nq_q  <= {nq_q[NW-2:0], ge};
      rem_q <= ge ? diff[TW-1:0] : r2[TW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

### tb/sv/pid_conditional_antiwindup_test.sv
// Self-checking testbench for the conditional anti-windup PID step block.
// Drives stream transactions and configuration writes and checks each result against
// its own fixed-point predictor. Depends on pca_pkg and pid_conditional_antiwindup.
module pid_conditional_antiwindup_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam int SETTLE_CYCLES = 250;

  typedef struct {
    logic [31:0] drive;
    logic        clamped;
  } drive_t;

  typedef struct {
    logic        clear;
    logic [31:0] target;
    logic [31:0] meas;
    logic [15:0] tstep;
    bit          typed;
    drive_t      res;
  } step_row_t;

  typedef struct {
    bit     typed;
    drive_t res;
  } typed_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [pca_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [pca_pkg::CFG_W-1:0] cfg_data_i = '0;

  // Predictor copy of the registers and controller state.
  longint kp_q, ki_q, kd_q, out_lim, integ_lim;
  longint integ_acc, prev_meas;
  bit     first_pending;

  drive_t    drive_q[$];
  typed_t    typed_q[$];
  step_row_t rows[$];

  int idle_mode = 0;   // 0: sender 31 / receiver 52, 1: swapped, 2: no idling
  int hold_req = 0;
  int mismatches = 0;
  int steps_sent = 0;
  int results_seen = 0;
  int clears_sent = 0;

  pid_conditional_antiwindup DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint sat_q(longint v);
    return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
  endfunction

  // Products fit in 64 bits at this width; the arithmetic shift rounds toward minus infinity.
  function automatic longint fx_mul(longint a, longint b, int sh);
    longint p;
    p = a * b;
    return sat_q(p >>> sh);
  endfunction

  function automatic drive_t pid_step(logic clear, logic [31:0] tgt, logic [31:0] msr,
                                      logic [15:0] ts);
    drive_t r;
    longint sp, ms, err, p_out, i_out, d_out, pot, o, delta, mag, q, deriv, thr;
    r.drive = '0;
    r.clamped = 1'b0;
    thr = ((64'd1 << pca_pkg::FRAC_BITS_DEF) + 50) / 100;
    if (clear == pca_pkg::REQ_CLEAR) begin
      integ_acc = 0;
      prev_meas = 0;
      first_pending = 1'b1;
      return r;
    end
    if (ts == 0) return r;
    sp = longint'($signed(tgt));
    ms = longint'($signed(msr));
    // A setpoint near zero discards the accumulated integral.
    if (sp < thr && sp > -thr) integ_acc = 0;
    err = sat_q(sp - ms);
    p_out = fx_mul(kp_q, err, pca_pkg::FRAC_BITS_DEF);
    pot = sat_q(p_out + fx_mul(ki_q, integ_acc, pca_pkg::FRAC_BITS_DEF));
    if ((pot < out_lim && pot > -out_lim) || (err > 0 && pot < -out_lim) ||
        (err < 0 && pot > out_lim)) begin
      integ_acc = sat_q(integ_acc + fx_mul(err, longint'(ts), pca_pkg::STEP_FRAC));
      if (integ_acc > integ_lim) integ_acc = integ_lim;
      if (integ_acc < -integ_lim) integ_acc = -integ_lim;
    end
    i_out = fx_mul(ki_q, integ_acc, pca_pkg::FRAC_BITS_DEF);
    d_out = 0;
    if (!first_pending) begin
      delta = sat_q(ms - prev_meas);
      mag = delta < 0 ? -delta : delta;
      q = (mag << pca_pkg::STEP_FRAC) / longint'(ts);
      if (delta >= 0) deriv = q > QMAX ? QMAX : q;
      else deriv = q > -QMIN ? QMIN : -q;
      d_out = fx_mul(kd_q, deriv, pca_pkg::FRAC_BITS_DEF);
      d_out = d_out == QMIN ? QMAX : -d_out;
    end
    prev_meas = ms;
    first_pending = 1'b0;
    o = sat_q(sat_q(p_out + i_out) + d_out);
    if (o > out_lim) begin
      o = out_lim;
      r.clamped = 1'b1;
    end
    if (o < -out_lim) begin
      o = -out_lim;
      r.clamped = 1'b1;
    end
    r.drive = o[31:0];
    return r;
  endfunction

  // Input side: predict at each accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      typed_t t;
      drive_t r;
      t = typed_q.pop_front();
      r = pid_step(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                   s_axis_tdata[79:64]);
      drive_q.push_back(t.typed ? t.res : r);
    end
  end

  // Output side: compare with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      drive_t e;
      results_seen++;
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: drive=%h clamped=%b",
                                       m_axis_tdata, m_axis_tuser);
      end else begin
        e = drive_q.pop_front();
        if (m_axis_tdata !== e.drive || m_axis_tuser !== e.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on result %0d: expected drive=%h clamped=%b, got drive=%h clamped=%b",
                     results_seen, e.drive, e.clamped, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  // Receiver with random stalls and a single long hold-off.
  always @(posedge clk_i) begin
    int hold_left;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_mode == 0) begin
      m_axis_tready <= ($urandom_range(99) >= 52);
    end else if (idle_mode == 1) begin
      m_axis_tready <= ($urandom_range(99) >= 31);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #50ms;
    $display("Timeout: %0d results outstanding", drive_q.size());
    $display("Some tests failed");
    $finish;
  end

  task automatic cfg_write(logic [pca_pkg::IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      pca_pkg::REG_KP:   kp_q = longint'($signed(val));
      pca_pkg::REG_KI:   ki_q = longint'($signed(val));
      pca_pkg::REG_KD:   kd_q = longint'($signed(val));
      pca_pkg::REG_OLIM: out_lim = longint'(val[30:0]);
      pca_pkg::REG_ILIM: integ_lim = longint'(val[30:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic cfg_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                         logic [31:0] olim, logic [31:0] ilim);
    cfg_write(pca_pkg::REG_KP, kp);
    cfg_write(pca_pkg::REG_KI, ki);
    cfg_write(pca_pkg::REG_KD, kd);
    cfg_write(pca_pkg::REG_OLIM, olim);
    cfg_write(pca_pkg::REG_ILIM, ilim);
  endtask

  // Returns at the edge that accepts the transaction.
  task automatic send_step(step_row_t row);
    typed_t t;
    int gap_pct;
    gap_pct = idle_mode == 0 ? 31 : (idle_mode == 1 ? 52 : 0);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    t.typed = row.typed;
    t.res = row.res;
    typed_q.push_back(t);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= row.clear;
    s_axis_tdata <= {row.tstep, row.meas, row.target};
    do @(posedge clk_i); while (!s_axis_tready);
    steps_sent++;
    if (row.clear == pca_pkg::REQ_CLEAR) clears_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic step_row_t mk(logic clear, logic [31:0] tgt, logic [31:0] msr,
                                   logic [15:0] ts, bit typed);
    step_row_t r;
    r.clear = clear;
    r.target = tgt;
    r.meas = msr;
    r.tstep = ts;
    r.typed = typed;
    r.res.drive = '0;
    r.res.clamped = 1'b0;
    return r;
  endfunction

  // Mostly values within a few units, sometimes the full range or an extreme.
  function automatic logic [31:0] rand_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return $urandom();
    if (pick < 22) return ($urandom_range(1) != 0) ? 32'h7fffffff : 32'h80000000;
    if (pick < 30) return 32'($urandom_range(1400)) - 32'd700;
    return 32'($urandom_range(32'h80000)) - 32'h40000;
  endfunction

  function automatic logic [31:0] rand_gain();
    if ($urandom_range(9) == 0) return $urandom();
    return 32'($urandom_range(32'h40000)) - 32'h20000;
  endfunction

  initial begin
    step_row_t r;
    int pick;
    kp_q = 0; ki_q = 0; kd_q = 0;
    out_lim = longint'(pca_pkg::LIM_RESET); integ_lim = longint'(pca_pkg::LIM_RESET);
    integ_acc = 0; prev_meas = 0; first_pending = 1'b1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset gains every result is zero and unclamped.
    rows.push_back(mk(1'b0, 32'h00010000, 32'h00000000, 16'h8000, 1));
    rows.push_back(mk(1'b0, 32'h7fffffff, 32'h80000000, 16'hffff, 1));
    rows.push_back(mk(1'b0, 32'h80000000, 32'h7fffffff, 16'h0001, 1));
    rows.push_back(mk(pca_pkg::REQ_CLEAR, 32'hffffffff, 32'hffffffff, 16'hffff, 1));
    rows.push_back(mk(1'b0, 32'h12345678, 32'h0, 16'h0000, 1));
    foreach (rows[i]) send_step(rows[i]);
    drain();
    rows.delete();

    cfg_all(32'h00010000, 32'h00008000, 32'h00004000, 32'h00100000, 32'h00040000);
    rows.push_back(mk(1'b0, 32'h00020000, 32'h00000000, 16'h4000, 0));
    rows.push_back(mk(1'b0, 32'h00020000, 32'h00010000, 16'h4000, 0));
    rows.push_back(mk(1'b0, 32'h00000100, 32'h00008000, 16'h1000, 0));  // below threshold
    rows.push_back(mk(1'b0, 32'hffffff00, 32'h00008000, 16'h1000, 0));
    rows.push_back(mk(1'b0, 32'h0000028f, 32'h00000000, 16'hffff, 0));  // at threshold
    rows.push_back(mk(1'b0, 32'h7fffffff, 32'h80000000, 16'hffff, 0));
    rows.push_back(mk(1'b0, 32'h80000000, 32'h7fffffff, 16'h0001, 0));
    rows.push_back(mk(1'b0, 32'h00010000, 32'h80000000, 16'h0001, 0));
    rows.push_back(mk(1'b0, 32'h00010000, 32'h00000000, 16'h0000, 1));  // zero step
    rows.push_back(mk(pca_pkg::REQ_CLEAR, 32'h0, 32'h0, 16'h0, 1));
    rows.push_back(mk(1'b0, 32'h00030000, 32'h7fffffff, 16'h0100, 0));  // first after clear
    rows.push_back(mk(1'b0, 32'h00030000, 32'h00000000, 16'h0001, 0));
    foreach (rows[i]) send_step(rows[i]);
    drain();
    rows.delete();

    // Zero output limit: the drive is pinned at zero.
    cfg_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h00000000, 32'h7fffffff);
    rows.push_back(mk(1'b0, 32'h00050000, 32'h00000000, 16'h8000, 0));
    rows.push_back(mk(1'b0, 32'hfffb0000, 32'h00000000, 16'h8000, 0));
    rows.push_back(mk(1'b0, 32'h00050000, 32'h00060000, 16'hffff, 0));
    foreach (rows[i]) send_step(rows[i]);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      idle_mode = phase < 4 ? 0 : (phase < 7 ? 1 : 2);
      case (phase)
        0: cfg_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        1: cfg_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h00010000, 32'h00000000);
        2: cfg_all(rand_gain(), rand_gain(), rand_gain(), 32'h00000000, 32'h00020000);
        default: cfg_all(rand_gain(), rand_gain(), rand_gain(),
                         32'($urandom_range(32'h200000, 32'h4000)),
                         32'($urandom_range(32'h100000, 32'h1000)));
      endcase
      // Hold the output long enough for the block to back up its input.
      if (phase == 4) hold_req = 3000;
      for (int n = 0; n < 125; n++) begin
        pick = $urandom_range(99);
        r = mk(pick < 5 ? pca_pkg::REQ_CLEAR : 1'b0, rand_value(), rand_value(),
               pick < 10 ? 16'h0 : (pick < 20 ? 16'($urandom()) :
                                    16'($urandom_range(16'h2000, 1))), 0);
        send_step(r);
      end
      drain();
    end

    if (drive_q.size() != 0) mismatches++;
    $display("Covered %0d transactions (%0d clears) and %0d results over 13 gain and limit settings.",
             steps_sent, clears_sent, results_seen);
    $display("Settings included extreme gains, zero and full-scale limits, and a long output stall.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/pca_pkg.sv
rtl/pca_mul.sv
rtl/pca_div.sv
rtl/pid_conditional_antiwindup.sv
tb/sv/pid_conditional_antiwindup_test.sv
